// File: hdl/tcms_pkg.sv
package tcms_pkg;

  localparam int unsigned DefRows     = 4;
  localparam int unsigned DefMaxWords = 1024;
  localparam int unsigned KeyW        = 64;
  localparam int unsigned CountW      = 32;
  localparam int unsigned EstW        = 33;
  localparam int unsigned RowIdxW     = 4;
  localparam int unsigned WprW        = 11;
  localparam int unsigned WprReset    = 1024;

  localparam logic ActUpdate = 1'b0;
  localparam logic ActQuery  = 1'b1;

  localparam logic [0:0] RegWordsPerRow = 1'b0;

  typedef struct packed {
    logic              valid;
    logic              action;
    logic [KeyW-1:0]   key;
    logic [CountW-1:0] count;
  } item_t;

  function automatic logic [63:0] row_seed(input logic [3:0] r);
    logic [63:0] s;
    case (r)
      4'd0:    s = 64'h243F6A8885A308D3;
      4'd1:    s = 64'h13198A2E03707344;
      4'd2:    s = 64'hA4093822299F31D0;
      4'd3:    s = 64'h082EFA98EC4E6C89;
      4'd4:    s = 64'h452821E638D01377;
      4'd5:    s = 64'hBE5466CF34E90C6C;
      4'd6:    s = 64'hC0AC29B7C97C50DD;
      4'd7:    s = 64'h3F84D5B5B5470917;
      4'd8:    s = 64'h9216D5D98979FB1B;
      4'd9:    s = 64'hD1310BA698DFB5AC;
      4'd10:   s = 64'h2FFD72DBD01ADFB7;
      4'd11:   s = 64'hB8E1AFED6A267E96;
      4'd12:   s = 64'hBA7C9045F12C7F99;
      4'd13:   s = 64'h24A19947B3916CF7;
      4'd14:   s = 64'h0801F2E2858EFC16;
      default: s = 64'h636920D871574E69;
    endcase
    return s;
  endfunction

endpackage

// File: hdl/tcms_ram.sv
module tcms_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// File: hdl/tcms_cell.sv
// One row of the sketch. The item enters from the left neighbor, the cell
// reduces key^seed modulo the row's slot count by restoring subtraction
// (one bit per cycle), does the tiered read-modify-write and passes it on.
module tcms_cell #(
  parameter int unsigned MAX_WORDS = 1024,
  parameter int unsigned ROW       = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       clear_en,
  input  logic [$clog2(4*MAX_WORDS)-1:0] clear_addr,
  input  logic [$clog2(4*MAX_WORDS):0]   slots,
  input  tcms_pkg::item_t            in_item,
  output tcms_pkg::item_t            out_item,
  output logic                       est_valid,
  output logic [tcms_pkg::EstW-1:0]  est
);
  import tcms_pkg::*;

  localparam int unsigned SW = $clog2(4*MAX_WORDS);
  localparam int unsigned RW = SW + 1;

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MOD  = 5'b00010,
    S_RD   = 5'b00100,
    S_WAIT = 5'b01000,
    S_WB   = 5'b10000
  } st_t;

  st_t           state;
  item_t         item;
  logic [63:0]   dividend;
  logic [6:0]    bitn;
  logic [RW-1:0] rem;
  logic [RW:0]   trial;
  logic [SW-1:0] slot;

  logic [7:0]    s_rd;
  logic [15:0]   m_rd;
  logic [31:0]   l_rd;
  logic          s_we, m_we, l_we;
  logic [7:0]    s_wd;
  logic [15:0]   m_wd;
  logic [31:0]   l_wd;

  logic [32:0]   s_sum;
  logic [33:0]   m_sum;
  logic [34:0]   l_sum;

  assign trial = {rem, dividend[63]} - {1'b0, slots};

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_item.valid <= 1'b0;
      est_valid     <= 1'b0;
    end else begin
      out_item.valid <= 1'b0;
      est_valid     <= 1'b0;
      case (state)
        S_IDLE: begin
          if (in_item.valid) begin
            item     <= in_item;
            dividend <= in_item.key ^ row_seed(4'(ROW));
            rem      <= '0;
            bitn     <= 7'd0;
            state    <= S_MOD;
          end
        end
        S_MOD: begin
          rem      <= trial[RW] ? RW'({rem, dividend[63]}) : trial[RW-1:0];
          dividend <= {dividend[62:0], 1'b0};
          bitn     <= bitn + 7'd1;
          if (bitn == 7'd63) begin
            state <= S_RD;
          end
        end
        S_RD: begin
          slot  <= rem[SW-1:0];
          state <= S_WAIT;
        end
        S_WAIT: state <= S_WB;
        S_WB: begin
          out_item  <= item;
          est_valid <= (item.action == ActQuery);
          if (s_rd != 8'hFF) begin
            est <= EstW'(s_rd);
          end else if (m_rd != 16'hFFFF) begin
            est <= EstW'(m_rd) + EstW'(255);
          end else begin
            est <= EstW'(l_rd) + EstW'(65790);
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Tiered add with spill, the large tier saturating; clear_en zeroes all tiers.
  always_comb begin
    s_sum = 33'(s_rd) + 33'(item.count);
    m_sum = 34'(m_rd) + 34'(s_sum) - 34'd255;
    l_sum = 35'(l_rd) + 35'(m_sum) - 35'd65535;
    s_we = 1'b0;
    m_we = 1'b0;
    l_we = 1'b0;
    s_wd = 8'hFF;
    m_wd = 16'hFFFF;
    l_wd = (l_sum > 35'hFFFFFFFF) ? 32'hFFFFFFFF : l_sum[31:0];
    if (state == S_WB && item.action == ActUpdate) begin
      s_we = 1'b1;
      if (s_sum <= 33'd255) begin
        s_wd = s_sum[7:0];
      end else begin
        m_we = 1'b1;
        if (m_sum <= 34'd65535) begin
          m_wd = m_sum[15:0];
        end else begin
          l_we = 1'b1;
        end
      end
    end
    if (clear_en) begin
      s_we = 1'b1;
      m_we = 1'b1;
      l_we = 1'b1;
      s_wd = '0;
      m_wd = '0;
      l_wd = '0;
    end
  end

  logic [SW-1:0] s_wa;
  assign s_wa = clear_en ? clear_addr : slot;

  tcms_ram #(.WIDTH(8), .DEPTH(4*MAX_WORDS)) u_small (
    .clk, .we(s_we), .waddr(s_wa), .wdata(s_wd), .raddr(slot), .rdata(s_rd));
  tcms_ram #(.WIDTH(16), .DEPTH(2*MAX_WORDS)) u_middle (
    .clk, .we(m_we), .waddr(s_wa[SW-1:1]), .wdata(m_wd), .raddr(slot[SW-1:1]),
    .rdata(m_rd));
  tcms_ram #(.WIDTH(32), .DEPTH(MAX_WORDS)) u_large (
    .clk, .we(l_we), .waddr(s_wa[SW-1:2]), .wdata(l_wd), .raddr(slot[SW-1:2]),
    .rdata(l_rd));
endmodule

// File: hdl/tiered_count_min_sketch_core.sv
// Tiered count-min sketch: ROWS cells in a chain, one per row, each with its
// own 8/16/32-bit counter memories. An item (s_axis_tdata) is an update or a
// query; it passes from cell to cell, and each cell does the bit-serial
// reduction of key^seed modulo 4*words_per_row, then the slot latch, the
// counter read and the write-back. One item is in the block at a time, so
// an update holds off the next request until the last cell is done, and a
// query also until its ROWS estimates have drained, one result per row in
// row order with tlast on the last row. After reset a clearing pass over
// all 4*MAX_WORDS slot addresses zeroes the counters; no request is taken
// until it ends. words_per_row (APB address 0) reads back its low 11 bits
// as written; 0 acts as 1 and values above MAX_WORDS act as MAX_WORDS.
// Write it only while the block is idle.
module tiered_count_min_sketch_core #(
  parameter int unsigned ROWS      = tcms_pkg::DefRows,
  parameter int unsigned MAX_WORDS = tcms_pkg::DefMaxWords
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         psel,
  input  logic         penable,
  input  logic         pwrite,
  input  logic [0:0]   paddr,
  input  logic [31:0]  pwdata,
  output logic [31:0]  prdata,
  output logic         pready,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [95:0]  s_axis_tdata,  // key[63:0], count[95:64]
  input  logic         s_axis_tuser,  // action
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [39:0]  m_axis_tdata,  // row_index[3:0], estimate[36:4], pad
  output logic         m_axis_tlast   // last_row
);
  import tcms_pkg::*;

  localparam int unsigned SW = $clog2(4*MAX_WORDS);

  logic [WprW-1:0] wpr;
  logic [SW:0]     slots;
  logic            busy;
  logic            clearing;
  logic [SW-1:0]   clear_addr;
  logic [$clog2(ROWS+1)-1:0] pend;  // results still owed
  logic [$clog2(ROWS)-1:0]   rd_ptr;

  item_t           link [ROWS+1];
  logic            est_v [ROWS];
  logic [EstW-1:0] est_d [ROWS];
  logic [EstW-1:0] est_q [ROWS];

  assign pready = 1'b1;
  assign prdata = 32'(wpr);

  always_ff @(posedge clk) begin
    if (rst) begin
      wpr <= WprW'(WprReset);
    end else if (psel && penable && pwrite && paddr == RegWordsPerRow) begin
      wpr <= pwdata[WprW-1:0];
    end
  end

  // Clamp width into 1..MAX_WORDS, four slots per word.
  always_comb begin
    if (wpr == '0) begin
      slots = (SW+1)'(4);
    end else if (32'(wpr) > MAX_WORDS) begin
      slots = (SW+1)'(4*MAX_WORDS);
    end else begin
      slots = (SW+1)'({wpr, 2'b00});
    end
  end

  assign s_axis_tready = !busy && !clearing;

  always_comb begin
    link[0].valid  = s_axis_tvalid && s_axis_tready;
    link[0].action = s_axis_tuser;
    link[0].key    = s_axis_tdata[63:0];
    link[0].count  = s_axis_tdata[95:64];
  end

  for (genvar r = 0; r < ROWS; r++) begin : g_row
    tcms_cell #(.MAX_WORDS(MAX_WORDS), .ROW(r)) u_cell (
      .clk, .rst, .clear_en(clearing), .clear_addr, .slots,
      .in_item(link[r]), .out_item(link[r+1]),
      .est_valid(est_v[r]), .est(est_d[r]));
    always_ff @(posedge clk) begin
      if (est_v[r]) begin
        est_q[r] <= est_d[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy       <= 1'b0;
      clearing   <= 1'b1;
      clear_addr <= '0;
      pend       <= '0;
      rd_ptr     <= '0;
    end else begin
      if (clearing) begin
        clear_addr <= clear_addr + 1'b1;
        if (clear_addr == SW'(4*MAX_WORDS-1)) begin
          clearing <= 1'b0;
        end
      end
      if (link[0].valid) begin
        busy <= 1'b1;
      end
      // Last cell done: release on update, start draining on query.
      if (link[ROWS].valid) begin
        if (link[ROWS].action == ActQuery) begin
          pend   <= ($clog2(ROWS+1))'(ROWS);
          rd_ptr <= '0;
        end else begin
          busy <= 1'b0;
        end
      end
      if (m_axis_tvalid && m_axis_tready) begin
        pend   <= pend - 1'b1;
        rd_ptr <= rd_ptr + 1'b1;
        if (pend == ($clog2(ROWS+1))'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  assign m_axis_tvalid = pend != '0;
  assign m_axis_tlast  = 32'(rd_ptr) == ROWS - 1;
  assign m_axis_tdata  = {3'b000, est_q[rd_ptr], RowIdxW'(rd_ptr)};
endmodule

// File: hdl/tcms_checker.sv
module tcms_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic        m_axis_tlast,
  input logic [39:0] m_axis_tdata
);
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken during drain");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result dropped");
  a_first_row: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> m_axis_tdata[3:0] == 4'd0) else $error("row order");
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> !m_axis_tvalid)
    else $error("result after last");
endmodule

bind tiered_count_min_sketch_core tcms_checker u_chk (.*);

// File: verif/testbench.sv
module testbench;
  import tcms_pkg::*;

  localparam int unsigned NumRows  = DefRows;
  localparam int unsigned MaxWords = DefMaxWords;
  localparam int unsigned NumItems = 410;
  // Wait after the queues empty: the work of every row plus the drain of the estimates.
  localparam int unsigned Latency  = 68 * NumRows + 40;
  localparam longint unsigned CycleLimit = 64'd3_000_000;

  typedef struct {
    logic          action;
    logic [63:0]   key;
    logic [31:0]   count;
  } request_t;

  typedef struct {
    logic [3:0]  row_index;
    logic [32:0] estimate;
    logic        last_row;
  } estimate_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         psel = 1'b0;
  logic         penable = 1'b0;
  logic         pwrite = 1'b0;
  logic [0:0]   paddr = '0;
  logic [31:0]  pwdata = '0;
  logic [31:0]  prdata;
  logic         pready;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [95:0]  s_axis_tdata = '0;  // key[63:0], count[95:64]
  logic         s_axis_tuser = 1'b0;  // action
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [39:0]  m_axis_tdata;  // row_index[3:0], estimate[36:4], pad
  logic         m_axis_tlast;

  tiered_count_min_sketch_core i_dut (.*);

  always #5 clk = ~clk;

  // Sketch mirror: counters and row width.
  logic [7:0]  small_tier [NumRows][4*MaxWords];
  logic [15:0] middle_tier[NumRows][2*MaxWords];
  logic [31:0] large_tier [NumRows][MaxWords];
  logic [10:0] width_reg;

  request_t  pending_requests[$];
  estimate_t expected_estimates[$];
  int        fail_count = 0;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  longint unsigned cycle_count = 0;
  logic      in_fire = 1'b0;  // request taken at the last rising edge

  function automatic int unsigned slot_index(int unsigned row, logic [63:0] key);
    logic [63:0] slots;
    logic [10:0] w;
    w = width_reg;
    if (w == 11'd0) w = 11'd1;
    if (w > MaxWords) w = 11'(MaxWords);
    slots = 64'(w) * 4;
    return 32'((key ^ row_seed(4'(row))) % slots);
  endfunction

  // Apply an update to the mirror, or queue the per-row estimates of a query.
  task automatic apply_sketch(request_t req);
    int unsigned s;
    logic [63:0] sum8, sum16, sum32;
    estimate_t e;
    for (int unsigned r = 0; r < NumRows; r++) begin
      s = slot_index(r, req.key);
      if (req.action == ActUpdate) begin
        sum8 = 64'(small_tier[r][s]) + 64'(req.count);
        if (sum8 <= 64'hFF) begin
          small_tier[r][s] = sum8[7:0];
          continue;
        end
        small_tier[r][s] = 8'hFF;
        sum16 = 64'(middle_tier[r][s/2]) + (sum8 - 64'hFF);
        if (sum16 <= 64'hFFFF) begin
          middle_tier[r][s/2] = sum16[15:0];
          continue;
        end
        middle_tier[r][s/2] = 16'hFFFF;
        sum32 = 64'(large_tier[r][s/4]) + (sum16 - 64'hFFFF);
        large_tier[r][s/4] = (sum32 > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum32[31:0];
      end else begin
        if (small_tier[r][s] < 8'hFF) e.estimate = 33'(small_tier[r][s]);
        else if (middle_tier[r][s/2] < 16'hFFFF) e.estimate = 33'(middle_tier[r][s/2]) + 33'd255;
        else e.estimate = 33'(large_tier[r][s/4]) + 33'd65790;
        e.row_index = 4'(r);
        e.last_row  = (r == NumRows - 1);
        expected_estimates.push_back(e);
      end
    end
  endtask

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycle_count);
    fail_count++;
  endtask

  // Driver: present requests at the falling edge, advance on acceptance.
  always @(negedge clk) begin
    if (!rst) begin
      if (in_fire) begin
        apply_sketch(pending_requests.pop_front());
      end
      // Hold a request that is still waiting; otherwise pick the next one.
      if (!s_axis_tvalid || in_fire) begin
        if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          s_axis_tvalid <= 1'b1;
          s_axis_tuser  <= pending_requests[0].action;
          s_axis_tdata  <= {pending_requests[0].count, pending_requests[0].key};
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Monitor: check each accepted estimate against the oldest expectation.
  always @(posedge clk) begin
    estimate_t want;
    cycle_count <= cycle_count + 1;
    in_fire <= !rst && s_axis_tvalid && s_axis_tready;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_estimates.size() == 0) begin
        report_mismatch("unexpected estimate", 64'(m_axis_tdata), 64'h0);
      end else begin
        want = expected_estimates.pop_front();
        if (m_axis_tdata[3:0] !== want.row_index)
          report_mismatch("row_index", 64'(m_axis_tdata[3:0]), 64'(want.row_index));
        if (m_axis_tdata[36:4] !== want.estimate)
          report_mismatch("estimate", 64'(m_axis_tdata[36:4]), 64'(want.estimate));
        if (m_axis_tlast !== want.last_row)
          report_mismatch("last_row", 64'(m_axis_tlast), 64'(want.last_row));
      end
    end
    if (cycle_count > CycleLimit) begin
      $display("timeout at cycle %0d", cycle_count);
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic push_request(logic action, logic [63:0] key, logic [31:0] count);
    request_t req;
    req.action = action;
    req.key    = key;
    req.count  = count;
    pending_requests.push_back(req);
  endtask

  task automatic drain_all();
    while (pending_requests.size() > 0 || s_axis_tvalid || expected_estimates.size() > 0)
      @(posedge clk);
    repeat (Latency) @(posedge clk);
  endtask

  // Write the row width while the block is idle.
  task automatic write_width(logic [10:0] w);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= RegWordsPerRow; pwdata <= 32'(w);
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    width_reg = w;
  endtask

  // Random request: mostly keys from a small hot set so counters grow and spill.
  task automatic random_request(logic [63:0] hot[8]);
    logic [63:0] key;
    logic [31:0] count;
    key = ($urandom_range(3) == 0) ? {$urandom, $urandom} : hot[$urandom_range(7)];
    case ($urandom_range(5))
      0: count = 32'($urandom_range(3));
      1: count = 32'($urandom_range(300));
      2: count = 32'($urandom_range(70000));
      3: count = 32'hFFFF_FFFF - 32'($urandom_range(3));
      default: count = $urandom;
    endcase
    push_request(($urandom_range(2) == 0) ? ActQuery : ActUpdate, key, count);
  endtask

  initial begin
    logic [63:0] hot[8];
    logic [10:0] widths[6];
    widths = '{11'd1, 11'd0, 11'd2047, 11'd3, 11'd1024, 11'd37};
    width_reg = 11'(WprReset);
    foreach (small_tier[r, i]) small_tier[r][i] = '0;
    foreach (middle_tier[r, i]) middle_tier[r][i] = '0;
    foreach (large_tier[r, i]) large_tier[r][i] = '0;
    foreach (hot[i]) hot[i] = {$urandom, $urandom};
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: extreme keys and counts, spills into each tier, saturation.
    push_request(ActQuery, 64'h0, 32'h0);
    push_request(ActUpdate, 64'h8000_0000_0000_0000, 32'h0);
    push_request(ActUpdate, 64'h7FFF_FFFF_FFFF_FFFF, 32'd254);
    push_request(ActQuery, 64'h7FFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    push_request(ActUpdate, 64'h7FFF_FFFF_FFFF_FFFF, 32'd1);
    push_request(ActQuery, 64'h7FFF_FFFF_FFFF_FFFF, 32'h0);
    push_request(ActUpdate, 64'hFFFF_FFFF_FFFF_FFFF, 32'd65800);
    push_request(ActQuery, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    push_request(ActUpdate, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    push_request(ActUpdate, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    push_request(ActQuery, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0);
    push_request(ActQuery, 64'h8000_0000_0000_0000, 32'h0);
    push_request(ActUpdate, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA);
    push_request(ActQuery, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555);
    drain_all();

    // Random phases across widths and idling patterns; counters persist.
    for (int ph = 0; ph < 6; ph++) begin
      write_width(widths[ph]);
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 87; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 87; end
        default: begin send_idle_pct = 31; recv_stall_pct = 31; end
      endcase
      for (int n = 0; n < NumItems / 6; n++) begin
        random_request(hot);
        // Hold off once until everything outstanding has arrived.
        if (ph == 0 && n == 20) begin
          while (pending_requests.size() > 0 || s_axis_tvalid ||
                 expected_estimates.size() > 0) @(posedge clk);
        end
      end
      drain_all();
    end

    if (fail_count == 0 && expected_estimates.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
